@@ src/qxmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_pkg
// Shared widths, constants and types of the X-frame quad motor mixer.
// ----------------------------------------------------------------------------
package qxmm_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int NUM_STAGES = 6;

    localparam int CMD_W  = 16;
    localparam int THR_W  = 10;
    localparam int WGT_W  = 17;
    localparam int PCT_W  = 7;
    localparam int MOT_W  = 10;
    localparam int MIX_W  = 11;   // mix after the +/-1000 limit
    localparam int LIM_W  = 11;   // floor / ceiling, up to 1270
    localparam int CNUM_W = 26;   // curve numerator, |x| <= 2e7
    localparam int PROD_W = 43;   // weight * curve numerator
    localparam int DIVV_W = 22;   // biased value / 32
    localparam int QUO_W  = 12;   // biased quotient
    localparam int SUM_W  = 14;   // throttle + signed delta

    localparam int MIX_LIMIT = 1000;

    localparam logic [PCT_W-1:0] MAX_THR_RST = 7'd80;
    localparam logic [PCT_W-1:0] IDLE_RST    = 7'd20;
    localparam logic [PCT_W-1:0] MAX_PWM_RST = 7'd100;

    // curve: p * (11000 + 9*|p|) / 20000
    localparam logic [14:0] CURVE_LIN = 15'd11000;
    localparam logic [13:0] CURVE_SQ  = 14'd9;

    // floor(q / 20000) = floor((q + 2048*20000) / 32 / 625) - 2048
    localparam logic signed [27:0] DIV_BIAS  = 28'sd40960000;
    localparam logic [QUO_W-1:0]   QUO_BIAS  = 12'd2048;
    localparam logic [22:0]        RECIP_625 = 23'd6871948;  // ceil(2^32 / 625)
    localparam int                 RECIP_SH  = 32;

    localparam logic [MOT_W-1:0] OUT_MAX = 10'd1023;

    typedef enum logic [1:0] {
        CFG_MAX_THR    = 2'd0,
        CFG_IDLE_SPEED = 2'd1,
        CFG_MAX_PWM    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PCT_W-1:0] max_thr;
        logic [PCT_W-1:0] idle;
        logic [PCT_W-1:0] max_pwm;
    } t_cfg;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [LIM_W-1:0] lo;
        logic [LIM_W-1:0] hi;
        logic             armed;
    } t_side;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    typedef logic signed [MIX_W-1:0] t_mix;
    typedef logic [QUO_W-1:0]        t_quo;

endpackage

@@ src/quad_x_motor_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// X-frame quadcopter motor mixer with curve shaping and motor limits.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with roll, pitch, yaw, throttle, weight and
// the two flags; a transaction completes when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall with the four motor drive values.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (0 throttle limit, 1 idle floor, 2 motor ceiling); write only when idle.
// Six register stages (mix, curve, weight product, scaling, reciprocal divide,
// limit/output register). One transaction per cycle is sustained while i_stall
// is low; the 43-bit weight product has its own stage and the divide by 20000
// is split over the scaling and reciprocal divide stages.
// Reset clears all stage valid bits and loads the register defaults (80, 20,
// 100). When i_stall holds a result, the stages behind it keep moving until
// they fill; o_stall rises only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [qxmm_pkg::CMD_W-1:0] i_roll_cmd,
    input  logic signed [qxmm_pkg::CMD_W-1:0] i_pitch_cmd,
    input  logic signed [qxmm_pkg::CMD_W-1:0] i_yaw_cmd,
    input  logic [qxmm_pkg::THR_W-1:0]        i_base_throttle,
    input  logic [qxmm_pkg::WGT_W-1:0]        i_throttle_weight,
    input  logic                              i_throttle_low,
    input  logic                              i_armed,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [qxmm_pkg::MOT_W-1:0]        o_motor_front_a,
    output logic [qxmm_pkg::MOT_W-1:0]        o_motor_front_b,
    output logic [qxmm_pkg::MOT_W-1:0]        o_motor_rear_a,
    output logic [qxmm_pkg::MOT_W-1:0]        o_motor_rear_b,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [qxmm_pkg::PCT_W-1:0]        i_cfg_data
);
    import qxmm_pkg::*;

    localparam int SIDE_DEPTH = NUM_STAGES - 2;

    t_cfg             cfg;
    t_pipe_ctl        ctl;
    t_mix             p1 [NUM_MOTORS];
    logic [WGT_W-1:0] w1;
    t_side            side1;
    t_quo             quo [NUM_MOTORS];
    logic [MOT_W-1:0] motor [NUM_MOTORS];

    logic [NUM_STAGES-1:0] r_vld;
    logic [WGT_W-1:0]      r_w2;
    t_side                 r_side [SIDE_DEPTH];

    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        ctl.en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !r_vld[k] || ctl.en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ctl.en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // throttle weight is used in stage 3, limit data in stage 6
    always_ff @(posedge i_clk) begin
        if (ctl.en[1]) begin
            r_w2      <= w1;
            r_side[0] <= side1;
        end
        for (int k = 1; k < SIDE_DEPTH; k++) begin
            if (ctl.en[k+1]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    qxmm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    qxmm_mix u_mix (
        .i_clk             (i_clk),
        .i_ctl             (ctl),
        .i_cfg             (cfg),
        .i_roll_cmd        (i_roll_cmd),
        .i_pitch_cmd       (i_pitch_cmd),
        .i_yaw_cmd         (i_yaw_cmd),
        .i_base_throttle   (i_base_throttle),
        .i_throttle_weight (i_throttle_weight),
        .i_throttle_low    (i_throttle_low),
        .i_armed           (i_armed),
        .o_p               (p1),
        .o_w               (w1),
        .o_side            (side1)
    );

    for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_lane
        qxmm_curve_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_p   (p1[g]),
            .i_w   (r_w2),
            .o_quo (quo[g])
        );
    end

    qxmm_limit u_limit (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_side  (r_side[SIDE_DEPTH-1]),
        .i_quo   (quo),
        .o_motor (motor)
    );

    assign o_stall         = !ctl.en[0];
    assign o_valid         = r_vld[NUM_STAGES-1];
    assign o_motor_front_a = motor[0];
    assign o_motor_front_b = motor[1];
    assign o_motor_rear_a  = motor[2];
    assign o_motor_rear_b  = motor[3];

    // input side only stalls once every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // an item entering an empty pipeline reaches o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (r_vld == '0)) |-> ##6 o_valid)
        else $error("transaction did not reach the output in time");

endmodule

@@ src/qxmm_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_cfg_regs
// Configuration registers: throttle limit, idle floor and motor ceiling.
// ----------------------------------------------------------------------------
module qxmm_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [qxmm_pkg::PCT_W-1:0]  i_cfg_data,
    output qxmm_pkg::t_cfg              o_cfg
);
    import qxmm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_THR:    n_cfg.max_thr = i_cfg_data;
                CFG_IDLE_SPEED: n_cfg.idle    = i_cfg_data;
                CFG_MAX_PWM:    n_cfg.max_pwm = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_thr <= MAX_THR_RST;
            r_cfg.idle    <= IDLE_RST;
            r_cfg.max_pwm <= MAX_PWM_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/qxmm_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_mix
// Stage 1: yaw limit, X-frame mixing, +/-1000 mix limit, floor and ceiling.
// ----------------------------------------------------------------------------
module qxmm_mix (
    input  logic                        i_clk,
    input  qxmm_pkg::t_pipe_ctl         i_ctl,
    input  qxmm_pkg::t_cfg              i_cfg,
    input  logic signed [qxmm_pkg::CMD_W-1:0] i_roll_cmd,
    input  logic signed [qxmm_pkg::CMD_W-1:0] i_pitch_cmd,
    input  logic signed [qxmm_pkg::CMD_W-1:0] i_yaw_cmd,
    input  logic [qxmm_pkg::THR_W-1:0]  i_base_throttle,
    input  logic [qxmm_pkg::WGT_W-1:0]  i_throttle_weight,
    input  logic                        i_throttle_low,
    input  logic                        i_armed,
    output qxmm_pkg::t_mix              o_p [qxmm_pkg::NUM_MOTORS],
    output logic [qxmm_pkg::WGT_W-1:0]  o_w,
    output qxmm_pkg::t_side             o_side
);
    import qxmm_pkg::*;

    localparam logic signed [CMD_W+1:0] MIX_HI = (CMD_W+2)'(MIX_LIMIT);
    localparam logic signed [CMD_W+1:0] MIX_LO = -MIX_HI;

    logic [9:0]                ylim_u;
    logic signed [CMD_W:0]     ylim;
    logic signed [CMD_W:0]     yaw_x;
    logic signed [CMD_W:0]     yaw_c;
    logic signed [CMD_W+1:0]   roll_e;
    logic signed [CMD_W+1:0]   pitch_e;
    logic signed [CMD_W+1:0]   yaw_e;
    logic signed [CMD_W+1:0]   mix [NUM_MOTORS];
    logic signed [CMD_W+1:0]   mix_c [NUM_MOTORS];
    t_side                     side;

    t_mix                      r_p [NUM_MOTORS];
    logic [WGT_W-1:0]          r_w;
    t_side                     r_side;

    always_comb begin
        ylim_u = 10'({3'b000, i_cfg.max_thr}) * 10'd5;
        ylim   = $signed({7'b0, ylim_u});
        yaw_x  = (CMD_W+1)'(i_yaw_cmd);
        if (yaw_x < -ylim) begin
            yaw_c = -ylim;
        end else if (yaw_x > ylim) begin
            yaw_c = ylim;
        end else begin
            yaw_c = yaw_x;
        end

        roll_e  = (CMD_W+2)'(i_roll_cmd);
        pitch_e = (CMD_W+2)'(i_pitch_cmd);
        yaw_e   = (CMD_W+2)'(yaw_c);

        mix[0] = -roll_e + pitch_e + yaw_e;
        mix[1] =  roll_e + pitch_e - yaw_e;
        mix[2] =  roll_e - pitch_e + yaw_e;
        mix[3] = -roll_e - pitch_e - yaw_e;

        for (int k = 0; k < NUM_MOTORS; k++) begin
            if (mix[k] < MIX_LO) begin
                mix_c[k] = MIX_LO;
            end else if (mix[k] > MIX_HI) begin
                mix_c[k] = MIX_HI;
            end else begin
                mix_c[k] = mix[k];
            end
        end

        side.thr   = i_base_throttle;
        side.lo    = i_throttle_low ? '0 : LIM_W'({4'b0000, i_cfg.idle}) * LIM_W'(10);
        side.hi    = LIM_W'({4'b0000, i_cfg.max_pwm}) * LIM_W'(10);
        side.armed = i_armed;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_p[k] <= mix_c[k][MIX_W-1:0];
            end
            r_w    <= i_throttle_weight;
            r_side <= side;
        end
    end

    assign o_p    = r_p;
    assign o_w    = r_w;
    assign o_side = r_side;

endmodule

@@ src/qxmm_curve_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_curve_lane
// Stages 2-5 of one motor: curve numerator, weight product, /20000 floor.
// ----------------------------------------------------------------------------
module qxmm_curve_lane (
    input  logic                        i_clk,
    input  qxmm_pkg::t_pipe_ctl         i_ctl,
    input  qxmm_pkg::t_mix              i_p,
    input  logic [qxmm_pkg::WGT_W-1:0]  i_w,
    output qxmm_pkg::t_quo              o_quo
);
    import qxmm_pkg::*;

    logic signed [MIX_W-1:0]       ap;
    logic [13:0]                   sq;
    logic [14:0]                   fac;
    logic signed [MIX_W+15:0]      cnum_full;
    logic signed [PROD_W:0]        prod_full;
    logic signed [PROD_W-17:0]     q;
    logic signed [27:0]            u_s;
    logic [DIVV_W+22:0]            quo_full;

    logic signed [CNUM_W-1:0]      r_cnum;
    logic signed [PROD_W-1:0]      r_prod;
    logic [DIVV_W-1:0]             r_v;
    t_quo                          r_quo;

    always_comb begin
        // stage 2: p * (11000 + 9*|p|)
        ap        = (i_p < 0) ? -i_p : i_p;
        sq        = 14'(ap[MIX_W-2:0]) * CURVE_SQ;
        fac       = CURVE_LIN + 15'(sq);
        cnum_full = i_p * $signed({1'b0, fac});
        // stage 3: weight product
        prod_full = $signed({1'b0, i_w}) * r_cnum;
        // stage 4: floor by 65536, bias positive, drop the factor 32
        q         = r_prod[PROD_W-1:16];
        u_s       = 28'(q) + DIV_BIAS;
        // stage 5: divide by 625 with a reciprocal
        quo_full  = (DIVV_W+23)'(r_v) * (DIVV_W+23)'(RECIP_625);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_cnum <= cnum_full[CNUM_W-1:0];
        end
        if (i_ctl.en[2]) begin
            r_prod <= prod_full[PROD_W-1:0];
        end
        if (i_ctl.en[3]) begin
            r_v <= u_s[26:5];
        end
        if (i_ctl.en[4]) begin
            r_quo <= quo_full[RECIP_SH+QUO_W-1:RECIP_SH];
        end
    end

    assign o_quo = r_quo;

endmodule

@@ src/qxmm_limit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_limit
// Stage 6: add throttle, floor/ceiling limit, disarm gating, output register.
// ----------------------------------------------------------------------------
module qxmm_limit (
    input  logic                        i_clk,
    input  qxmm_pkg::t_pipe_ctl         i_ctl,
    input  qxmm_pkg::t_side             i_side,
    input  qxmm_pkg::t_quo              i_quo [qxmm_pkg::NUM_MOTORS],
    output logic [qxmm_pkg::MOT_W-1:0]  o_motor [qxmm_pkg::NUM_MOTORS]
);
    import qxmm_pkg::*;

    logic signed [SUM_W-1:0] m   [NUM_MOTORS];
    logic signed [SUM_W-1:0] mc  [NUM_MOTORS];
    logic [MOT_W-1:0]        mot [NUM_MOTORS];
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic signed [SUM_W-1:0] top_s;

    logic [MOT_W-1:0]        r_motor [NUM_MOTORS];

    always_comb begin
        lo_s  = $signed(SUM_W'(i_side.lo));
        hi_s  = $signed(SUM_W'(i_side.hi));
        top_s = $signed(SUM_W'(OUT_MAX));
        for (int k = 0; k < NUM_MOTORS; k++) begin
            m[k] = $signed(SUM_W'(i_side.thr)) + $signed(SUM_W'(i_quo[k]))
                 - $signed(SUM_W'(QUO_BIAS));
            // floor is checked first; a value at or above the floor is still held to the ceiling
            if (m[k] < lo_s) begin
                mc[k] = lo_s;
            end else if (m[k] > hi_s) begin
                mc[k] = hi_s;
            end else begin
                mc[k] = m[k];
            end
            if (!i_side.armed) begin
                mot[k] = '0;
            end else if (mc[k] > top_s) begin
                mot[k] = OUT_MAX;
            end else begin
                mot[k] = mc[k][MOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_motor[k] <= mot[k];
            end
        end
    end

    assign o_motor = r_motor;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the X-frame quad motor mixer. Commands are queued by
// the stimulus process and sent by a clocked driver with random gaps. A clocked
// monitor applies random back-pressure. Each accepted transaction is run
// through a local mixer model, and the four motor values that come back are
// compared in order. Register settings change between phases, once the block
// has drained.
// ----------------------------------------------------------------------------
module tb_top;

    import qxmm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_GAP     = 17;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_ITEMS = 200;
    localparam int WEIGHT_ONE  = 65536;

    typedef struct {
        logic signed [CMD_W-1:0] roll;
        logic signed [CMD_W-1:0] pitch;
        logic signed [CMD_W-1:0] yaw;
        logic [THR_W-1:0]        thr;
        logic [WGT_W-1:0]        wgt;
        logic                    thr_low;
        logic                    armed;
    } t_mix_cmd;

    // index 0 is front_a, 3 is rear_b
    typedef logic [NUM_MOTORS-1:0][MOT_W-1:0] t_motor_set;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [CMD_W-1:0] i_roll_cmd = '0;
    logic signed [CMD_W-1:0] i_pitch_cmd = '0;
    logic signed [CMD_W-1:0] i_yaw_cmd = '0;
    logic [THR_W-1:0]        i_base_throttle = '0;
    logic [WGT_W-1:0]        i_throttle_weight = '0;
    logic                    i_throttle_low = 1'b0;
    logic                    i_armed = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [MOT_W-1:0]        o_motor_front_a;
    logic [MOT_W-1:0]        o_motor_front_b;
    logic [MOT_W-1:0]        o_motor_rear_a;
    logic [MOT_W-1:0]        o_motor_rear_b;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_idx = '0;
    logic [PCT_W-1:0]        i_cfg_data = '0;

    t_mix_cmd   cmd_q [$];
    t_motor_set motor_exp_q [$];
    t_mix_cmd   cur_cmd;
    t_cfg       cfg_shadow = '{max_thr: MAX_THR_RST, idle: IDLE_RST, max_pwm: MAX_PWM_RST};

    bit    tx_active = 1'b0;
    bit    tx_burst = 1'b0;
    bit    rx_burst = 1'b0;
    int    tx_wait = 0;
    int    rx_wait = 0;
    int    hold_req_cnt = 0;
    int    hold_seen_cnt = 0;
    int    hold_left = 0;
    int    mismatch_cnt = 0;
    int    cycle_cnt = 0;
    string motor_name [NUM_MOTORS] = '{"motor_front_a", "motor_front_b",
                                       "motor_rear_a", "motor_rear_b"};

    quad_x_motor_mixer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_roll_cmd        (i_roll_cmd),
        .i_pitch_cmd       (i_pitch_cmd),
        .i_yaw_cmd         (i_yaw_cmd),
        .i_base_throttle   (i_base_throttle),
        .i_throttle_weight (i_throttle_weight),
        .i_throttle_low    (i_throttle_low),
        .i_armed           (i_armed),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_motor_front_a   (o_motor_front_a),
        .o_motor_front_b   (o_motor_front_b),
        .o_motor_rear_a    (o_motor_rear_a),
        .o_motor_rear_b    (o_motor_rear_b),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic void note_error(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // Mix, curve, weight and limits; everything stays exact until the final floor.
    function automatic t_motor_set predict_motors(t_mix_cmd c, t_cfg cfg);
        int         ylim;
        int         yaw_c;
        int         lo;
        int         hi;
        int         p;
        int         ap;
        int         mix [NUM_MOTORS];
        longint     den;
        longint     num;
        longint     m;
        t_motor_set r;
        ylim  = 5 * int'(cfg.max_thr);
        yaw_c = int'(c.yaw);
        if (yaw_c < -ylim) yaw_c = -ylim;
        else if (yaw_c > ylim) yaw_c = ylim;
        mix[0] = -int'(c.roll) + int'(c.pitch) + yaw_c;
        mix[1] =  int'(c.roll) + int'(c.pitch) - yaw_c;
        mix[2] =  int'(c.roll) - int'(c.pitch) + yaw_c;
        mix[3] = -int'(c.roll) - int'(c.pitch) - yaw_c;
        lo  = c.thr_low ? 0 : 10 * int'(cfg.idle);
        hi  = 10 * int'(cfg.max_pwm);
        den = longint'(20000) * WEIGHT_ONE;
        for (int k = 0; k < NUM_MOTORS; k++) begin
            p = mix[k];
            if (p < -MIX_LIMIT) p = -MIX_LIMIT;
            else if (p > MIX_LIMIT) p = MIX_LIMIT;
            ap  = (p < 0) ? -p : p;
            num = longint'(c.thr) * den
                + longint'(c.wgt) * (longint'(p) * longint'(11000 + 9 * ap));
            m = num / den;
            if ((num % den) != 0 && num < 0) m--;
            if (!c.armed) begin
                m = 0;
            end else begin
                if (m < lo) m = lo;
                else if (m > hi) m = hi;
                if (m > longint'(OUT_MAX)) m = longint'(OUT_MAX);
            end
            r[k] = m[MOT_W-1:0];
        end
        return r;
    endfunction

    // Sender: one transaction per command, random gap after each accept.
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            tx_active = 1'b0;
            tx_wait   = 0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && !o_stall) begin
                motor_exp_q.push_back(predict_motors(cur_cmd, cfg_shadow));
                nxt_valid = 1'b0;
                tx_wait   = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!nxt_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    i_roll_cmd        <= cur_cmd.roll;
                    i_pitch_cmd       <= cur_cmd.pitch;
                    i_yaw_cmd         <= cur_cmd.yaw;
                    i_base_throttle   <= cur_cmd.thr;
                    i_throttle_weight <= cur_cmd.wgt;
                    i_throttle_low    <= cur_cmd.thr_low;
                    i_armed           <= cur_cmd.armed;
                    nxt_valid = 1'b1;
                end
            end
            tx_active = nxt_valid;
            i_valid   <= nxt_valid;
        end
    end

    // Receiver: checks each transaction, then stalls for a random count.
    always @(posedge i_clk) begin
        t_motor_set got;
        t_motor_set want;
        logic       nxt_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_motor_rear_b, o_motor_rear_a, o_motor_front_b, o_motor_front_a};
                if (motor_exp_q.size() == 0) begin
                    note_error($sformatf("unexpected result %h", got));
                end else begin
                    want = motor_exp_q.pop_front();
                    for (int k = 0; k < NUM_MOTORS; k++) begin
                        if (got[k] !== want[k]) begin
                            note_error($sformatf("%s expected %0d got %0d",
                                                 motor_name[k], want[k], got[k]));
                        end
                    end
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold_seen_cnt != hold_req_cnt) begin
                hold_seen_cnt++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                nxt_stall = 1'b1;
            end else begin
                nxt_stall = 1'b0;
            end
            i_stall <= nxt_stall;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_mix_cmd mk_cmd(int roll, int pitch, int yaw, int thr, int wgt,
                                        bit thr_low, bit armed);
        t_mix_cmd c;
        c.roll    = CMD_W'(roll);
        c.pitch   = CMD_W'(pitch);
        c.yaw     = CMD_W'(yaw);
        c.thr     = THR_W'(thr);
        c.wgt     = WGT_W'(wgt);
        c.thr_low = thr_low;
        c.armed   = armed;
        return c;
    endfunction

    // Mostly flight-sized corrections, with full-range and extreme values mixed in.
    function automatic logic signed [CMD_W-1:0] rand_corr();
        logic signed [CMD_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = CMD_W'($urandom);
            1: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: v = CMD_W'(int'($urandom_range(0, 2400)) - 1200);
        endcase
        return v;
    endfunction

    function automatic t_mix_cmd rand_cmd();
        t_mix_cmd c;
        c.roll  = rand_corr();
        c.pitch = rand_corr();
        c.yaw   = rand_corr();
        if ($urandom_range(0, 7) == 0) c.thr = THR_W'($urandom_range(0, 1) ? 1000 : 0);
        else c.thr = THR_W'($urandom_range(0, 1000));
        case ($urandom_range(0, 7))
            0: c.wgt = WGT_W'($urandom_range(0, 2 * WEIGHT_ONE - 1));
            1: c.wgt = WGT_W'(WEIGHT_ONE);
            2: c.wgt = '0;
            default: c.wgt = WGT_W'($urandom_range(0, WEIGHT_ONE));
        endcase
        c.thr_low = ($urandom_range(0, 3) == 0);
        c.armed   = ($urandom_range(0, 7) != 0);
        return c;
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() != 0 || tx_active || motor_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [PCT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_THR:    cfg_shadow.max_thr = val;
            CFG_IDLE_SPEED: cfg_shadow.idle = val;
            CFG_MAX_PWM:    cfg_shadow.max_pwm = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [PCT_W-1:0] thr_pct, logic [PCT_W-1:0] idle_pct,
                              logic [PCT_W-1:0] pwm_pct);
        write_reg(CFG_MAX_THR, thr_pct);
        write_reg(CFG_IDLE_SPEED, idle_pct);
        write_reg(CFG_MAX_PWM, pwm_pct);
    endtask

    // hold: sender runs back to back while the receiver blocks for a long stretch
    task automatic run_phase(int n_items, bit tx_b, bit rx_b, bit hold);
        tx_burst = tx_b | hold;
        rx_burst = rx_b;
        repeat (n_items) cmd_q.push_back(rand_cmd());
        if (hold) hold_req_cnt++;
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: yaw limit 400, floor 200, ceiling 1000
        cmd_q.push_back(mk_cmd(0, 0, 0, 0, 0, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(0, 0, 0, 0, 0, 1'b1, 1'b1));
        cmd_q.push_back(mk_cmd(32767, 32767, 32767, 1000, 65536, 1'b0, 1'b0));
        cmd_q.push_back(mk_cmd(32767, 0, 0, 500, 65536, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(-32768, 0, 0, 500, 65536, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(0, 32767, 0, 500, 65536, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(0, -32768, 0, 500, 65536, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(0, 0, 32767, 500, 65536, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(0, 0, -32768, 500, 65536, 1'b1, 1'b1));
        cmd_q.push_back(mk_cmd(500, 500, 0, 0, 65536, 1'b1, 1'b1));
        cmd_q.push_back(mk_cmd(1, 0, 0, 300, 1, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(-1, 0, 0, 300, 1, 1'b1, 1'b1));
        cmd_q.push_back(mk_cmd(300, -200, 100, 1000, 131071, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(-400, 250, -100, 700, 98304, 1'b1, 1'b1));
        cmd_q.push_back(mk_cmd(0, 0, 0, 1000, 0, 1'b0, 1'b1));
        cmd_q.push_back(mk_cmd(200, -300, 50, 1000, 65536, 1'b0, 1'b1));
        run_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

        // limits past 100 percent: outputs saturate at the field maximum
        set_config(7'd127, 7'd127, 7'd127);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

        set_config(7'd0, 7'd0, 7'd0);
        run_phase(PHASE_ITEMS, 1'b1, 1'b1, 1'b0);

        set_config(7'd100, 7'd0, 7'd100);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0, 1'b1);

        // floor above ceiling
        set_config(7'd50, 7'd100, 7'd30);
        run_phase(PHASE_ITEMS, 1'b0, 1'b1, 1'b0);

        repeat (2) begin
            set_config(PCT_W'($urandom_range(0, 127)), PCT_W'($urandom_range(0, 127)),
                       PCT_W'($urandom_range(0, 127)));
            run_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
        end

        set_config(MAX_THR_RST, IDLE_RST, MAX_PWM_RST);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
